// ----- hw/rtl/rbsi_pkg.sv -----
package rbsi_pkg;

	// Q16.16 word and divider geometry
	localparam int unsigned QW     = 32;
	localparam int unsigned Q_FRAC = 16;
	localparam int unsigned DIFF_W = QW + 1;
	localparam int unsigned NUM_W  = DIFF_W + Q_FRAC;
	localparam int unsigned DEN_W  = QW;
	localparam int unsigned CMP_W  = DEN_W + QW;
	localparam int unsigned DIV_LAT = QW;
	localparam int unsigned EPS_W  = 17;
	localparam int unsigned NAXES  = 3;

	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	// configuration register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;
	localparam logic [2:0] REG_EPS   = 3'd6;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] near_distance;
	} res_t;

	// per-axis side information that travels beside the divider
	typedef struct packed {
		logic par;
		logic pmiss;
		logic neg_lo;
		logic neg_hi;
		logic ovf_lo;
		logic ovf_hi;
	} axis_meta_t;

	typedef axis_meta_t [NAXES-1:0] ray_meta_t;

endpackage

// ----- hw/rtl/rbsi_div.sv -----
module rbsi_div import rbsi_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QW-1:0]    quo
);

	// one quotient bit per stage, most significant first
	logic [NUM_W-1:0] rem_s [0:QW-1];
	logic [DEN_W-1:0] den_s [0:QW-1];
	logic [QW-1:0]    quo_s [0:QW];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign quo      = quo_s[QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [CMP_W-1:0] sub;
		logic             ge;

		assign sub = {{(CMP_W-DEN_W){1'b0}}, den_s[k]} << (QW - 1 - k);
		assign ge  = {{(CMP_W-NUM_W){1'b0}}, rem_s[k]} >= sub;

		// shift in the next quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_carry
			// reduce the partial remainder, pass the divisor on
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? rem_s[k] - sub[NUM_W-1:0] : rem_s[k];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

endmodule

// ----- hw/rtl/rbsi_fold.sv -----
module rbsi_fold import rbsi_pkg::*; (
	input  logic signed [QW-1:0] t_lo [NAXES],
	input  logic signed [QW-1:0] t_hi [NAXES],
	input  ray_meta_t            meta,
	output res_t                 res
);

	logic signed [QW-1:0] near_d;
	logic signed [QW-1:0] far_d;
	logic signed [QW-1:0] f;
	logic                 miss;

	// fold the axes in order X, Y, Z into near/far and the miss flag
	always_comb begin
		near_d = '0;
		far_d  = Q_MAX;
		f      = Q_MAX;
		miss   = 1'b0;
		for (int a = 0; a < NAXES; a++) begin
			if (meta[a].par) begin
				miss = miss | meta[a].pmiss;
			end else begin
				if (t_lo[a] > near_d) begin
					near_d = t_lo[a];
				end
				f = (t_hi[a] < far_d) ? t_hi[a] : far_d;
				far_d = f;
				if (near_d > f) begin
					miss = 1'b1;
				end
			end
		end
		res.hit           = ~miss;
		res.near_distance = miss ? '0 : near_d[30:0];
	end

endmodule

// ----- hw/rtl/ray_box_slab_intersection.sv -----
// channel | valid     | stall     | word
// --------+-----------+-----------+-----------------------------
// ray in  | ray_valid | ray_stall | ray (origin, direction)
// result  | res_valid | res_stall | res (hit, near_distance)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// One ray enters per cycle unless ray_stall is high; a result leaves after
// its ray has passed the setup stages, the restoring divider (one quotient
// bit per stage, six of them side by side) and the saturate, swap and fold stages.
// Reset clears the valid bits and loads the box and epsilon defaults.
// A stall at the result register freezes the whole pipeline in place.
module ray_box_slab_intersection import rbsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ray_valid,
	output logic        ray_stall,
	input  ray_t        ray,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [QW-1:0] box_min_q [NAXES];
	logic signed [QW-1:0] box_max_q [NAXES];
	logic [EPS_W-1:0]     eps_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NAXES; a++) begin
				box_min_q[a] <= '0;
				box_max_q[a] <= '0;
			end
			eps_q <= EPS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_X: box_min_q[0] <= cfg_data;
				REG_MIN_Y: box_min_q[1] <= cfg_data;
				REG_MIN_Z: box_min_q[2] <= cfg_data;
				REG_MAX_X: box_max_q[0] <= cfg_data;
				REG_MAX_Y: box_max_q[1] <= cfg_data;
				REG_MAX_Z: box_max_q[2] <= cfg_data;
				REG_EPS:   eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en        = ~(res_valid & res_stall);
	assign ray_stall = ~en;

	// stage 1: differences, direction magnitude, parallel test
	logic signed [QW-1:0]     org [NAXES];
	logic signed [QW-1:0]     dir [NAXES];
	logic signed [DIFF_W-1:0] dlo_c [NAXES];
	logic signed [DIFF_W-1:0] dhi_c [NAXES];
	logic [DEN_W-1:0]         mag_c [NAXES];
	logic [NAXES-1:0]         par_c;
	logic [NAXES-1:0]         pmiss_c;

	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	always_comb begin
		for (int a = 0; a < NAXES; a++) begin
			dlo_c[a]   = DIFF_W'(box_min_q[a]) - DIFF_W'(org[a]);
			dhi_c[a]   = DIFF_W'(box_max_q[a]) - DIFF_W'(org[a]);
			mag_c[a]   = dir[a][QW-1] ? DEN_W'(-dir[a]) : DEN_W'(dir[a]);
			par_c[a]   = (dir[a] == '0) || (mag_c[a] < {{(DEN_W-EPS_W){1'b0}}, eps_q});
			pmiss_c[a] = (org[a] < box_min_q[a]) || (org[a] > box_max_q[a]);
		end
	end

	logic                     v_s1;
	logic signed [DIFF_W-1:0] dlo_s1 [NAXES];
	logic signed [DIFF_W-1:0] dhi_s1 [NAXES];
	logic [DEN_W-1:0]         mag_s1 [NAXES];
	logic [NAXES-1:0]         dneg_s1;
	logic [NAXES-1:0]         par_s1;
	logic [NAXES-1:0]         pmiss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				dlo_s1[a]  <= dlo_c[a];
				dhi_s1[a]  <= dhi_c[a];
				mag_s1[a]  <= mag_c[a];
				dneg_s1[a] <= dir[a][QW-1];
			end
			par_s1   <= par_c;
			pmiss_s1 <= pmiss_c;
		end
	end

	// stage 2: dividend magnitudes, quotient signs, overflow test
	logic [NUM_W-1:0] nlo_c [NAXES];
	logic [NUM_W-1:0] nhi_c [NAXES];
	ray_meta_t        meta_c;

	always_comb begin
		for (int a = 0; a < NAXES; a++) begin
			nlo_c[a] = {(dlo_s1[a][DIFF_W-1] ? DIFF_W'(-dlo_s1[a]) : DIFF_W'(dlo_s1[a])),
				{Q_FRAC{1'b0}}};
			nhi_c[a] = {(dhi_s1[a][DIFF_W-1] ? DIFF_W'(-dhi_s1[a]) : DIFF_W'(dhi_s1[a])),
				{Q_FRAC{1'b0}}};
			meta_c[a].par    = par_s1[a];
			meta_c[a].pmiss  = pmiss_s1[a];
			meta_c[a].neg_lo = (dlo_s1[a][DIFF_W-1] ^ dneg_s1[a]) && (nlo_c[a] != '0);
			meta_c[a].neg_hi = (dhi_s1[a][DIFF_W-1] ^ dneg_s1[a]) && (nhi_c[a] != '0);
			meta_c[a].ovf_lo = {{(CMP_W-NUM_W){1'b0}}, nlo_c[a]} >= {mag_s1[a], {QW{1'b0}}};
			meta_c[a].ovf_hi = {{(CMP_W-NUM_W){1'b0}}, nhi_c[a]} >= {mag_s1[a], {QW{1'b0}}};
		end
	end

	logic             v_s2;
	logic [NUM_W-1:0] nlo_s2 [NAXES];
	logic [NUM_W-1:0] nhi_s2 [NAXES];
	logic [DEN_W-1:0] den_s2 [NAXES];
	ray_meta_t        meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				nlo_s2[a] <= nlo_c[a];
				nhi_s2[a] <= nhi_c[a];
				den_s2[a] <= mag_s1[a];
			end
			meta_s2 <= meta_c;
		end
	end

	// divider lanes
	logic [QW-1:0] qlo [NAXES];
	logic [QW-1:0] qhi [NAXES];

	for (genvar a = 0; a < NAXES; a++) begin : g_axis
		rbsi_div u_div_lo (
			.clk (clk),
			.en  (en),
			.num (nlo_s2[a]),
			.den (den_s2[a]),
			.quo (qlo[a])
		);
		rbsi_div u_div_hi (
			.clk (clk),
			.en  (en),
			.num (nhi_s2[a]),
			.den (den_s2[a]),
			.quo (qhi[a])
		);
	end

	// side line that keeps valid and meta aligned with the dividers
	logic      v_d    [DIV_LAT];
	ray_meta_t meta_d [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (en) begin
			v_d[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_d[0] <= meta_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				meta_d[i] <= meta_d[i-1];
			end
		end
	end

	// stage 3: apply sign and saturate
	function automatic logic signed [QW-1:0] sat_q(input logic [QW-1:0] q,
		input logic neg, input logic ovf);
		logic signed [QW-1:0] r;
		if (neg) begin
			r = (ovf || (q > {1'b1, {(QW-1){1'b0}}})) ? Q_MIN : -$signed(q);
		end else begin
			r = (ovf || q[QW-1]) ? Q_MAX : $signed(q);
		end
		return r;
	endfunction

	ray_meta_t            meta_l;
	logic                 v_s3;
	logic signed [QW-1:0] tlo_s3 [NAXES];
	logic signed [QW-1:0] thi_s3 [NAXES];
	ray_meta_t            meta_s3;

	assign meta_l = meta_d[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				tlo_s3[a] <= sat_q(qlo[a], meta_l[a].neg_lo, meta_l[a].ovf_lo);
				thi_s3[a] <= sat_q(qhi[a], meta_l[a].neg_hi, meta_l[a].ovf_hi);
			end
			meta_s3 <= meta_l;
		end
	end

	// stage 4: order entry and exit
	logic                 v_s4;
	logic signed [QW-1:0] tlo_s4 [NAXES];
	logic signed [QW-1:0] thi_s4 [NAXES];
	ray_meta_t            meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				if (tlo_s3[a] > thi_s3[a]) begin
					tlo_s4[a] <= thi_s3[a];
					thi_s4[a] <= tlo_s3[a];
				end else begin
					tlo_s4[a] <= tlo_s3[a];
					thi_s4[a] <= thi_s3[a];
				end
			end
			meta_s4 <= meta_s3;
		end
	end

	// stage 5: fold axes into the result register
	res_t res_c;
	logic v_s5;
	res_t res_s5;

	rbsi_fold u_fold (
		.t_lo (tlo_s4),
		.t_hi (thi_s4),
		.meta (meta_s4),
		.res  (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	assign res_valid = v_s5;
	assign res       = res_s5;

endmodule
